// ===== hw/rtl/asat_pkg.sv =====
// ============================================================================
// asat_pkg
// Shared types, constants and the microcode program of the sine saturator.
// ============================================================================
package asat_pkg;

    // Default sample and table sizes.
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Fixed-point constants of the sine path.
    localparam int INV_TWO_PI_Q32 = 683565276;   // round(2^32 / (2*pi))
    localparam int HALF_PI_Q30    = 1686629713;  // pi/2 in Q1.30
    localparam int ONE_Q30        = 1073741824;  // 1.0 in Q1.30
    localparam int TBL_DATA_W     = 31;          // table entries lie in [0, 2^30]

    // Drive register: a Q1.16 fraction with 1.0 as its top value.
    localparam int DRIVE_W    = 17;
    localparam int DRIVE_FRAC = 16;
    localparam int DRIVE_MAX  = 65536;

    // Microcode program size.
    localparam int STEP_W = 4;

    // Sequencer state.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // What the shared multiplier works on in a step.
    typedef enum logic [2:0] {
        MUL_HOLD,
        MUL_PHASE,
        MUL_INTERP,
        MUL_BLEND,
        MUL_WET,
        MUL_DRY
    } mul_op_t;

    // Sine table read: the lower or the upper point of an interval.
    typedef enum logic [1:0] {
        ROM_IDLE,
        ROM_LO,
        ROM_HI
    } rom_op_t;

    // Datapath register update in a step.
    typedef enum logic [3:0] {
        DP_NONE,
        DP_POS,
        DP_LATCH_LO,
        DP_DIFF,
        DP_MAG,
        DP_SINE,
        DP_SUM,
        DP_BLEND,
        DP_OMB,
        DP_ACC_LOAD,
        DP_ACC_ADD,
        DP_OUT
    } dp_op_t;

    // Step counter control.
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_CHAN,
        SEQ_END
    } seq_op_t;

    // One control word of the program.
    typedef struct packed {
        mul_op_t mul_op;
        rom_op_t rom_op;
        dp_op_t  dp_op;
        seq_op_t seq_op;
    } ucode_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        mul_op_t mul_op;
        rom_op_t rom_op;
        dp_op_t  dp_op;
        logic    chan;
        logic    in_load;
        logic    out_load;
    } dp_ctrl_t;

    // The program: steps 0 to 14 shape one channel, step 15 hands the pair
    // to the output register. The multiplier product and the table read data
    // are both registered, and each is used in the step after it is issued.
    function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{mul_op: MUL_HOLD, rom_op: ROM_IDLE, dp_op: DP_NONE, seq_op: SEQ_NEXT};
        case (step)
            4'd0:  w.mul_op = MUL_PHASE;
            4'd1:  w.dp_op  = DP_POS;
            4'd2:  w.rom_op = ROM_LO;
            4'd3: begin
                w.rom_op = ROM_HI;
                w.dp_op  = DP_LATCH_LO;
            end
            4'd4:  w.dp_op  = DP_DIFF;
            4'd5:  w.mul_op = MUL_INTERP;
            4'd6:  w.dp_op  = DP_MAG;
            4'd7:  w.dp_op  = DP_SINE;
            4'd8:  w.dp_op  = DP_SUM;
            4'd9:  w.mul_op = MUL_BLEND;
            4'd10: w.dp_op  = DP_BLEND;
            4'd11: begin
                w.mul_op = MUL_WET;
                w.dp_op  = DP_OMB;
            end
            4'd12: begin
                w.mul_op = MUL_DRY;
                w.dp_op  = DP_ACC_LOAD;
            end
            4'd13: w.dp_op  = DP_ACC_ADD;
            4'd14: begin
                w.dp_op  = DP_OUT;
                w.seq_op = SEQ_CHAN;
            end
            4'd15: w.seq_op = SEQ_END;
            default: w.seq_op = SEQ_END;
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/asat_sine_rom.sv =====
// ============================================================================
// asat_sine_rom
// Quarter-wave sine table, Q1.30, with a registered read port.
// ============================================================================
module asat_sine_rom #(
    parameter int SINE_TABLE_BITS = asat_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               rd_en,
    input  logic [SINE_TABLE_BITS:0]           rd_addr,
    output logic [asat_pkg::TBL_DATA_W-1:0]    rd_data
);
    import asat_pkg::*;

    localparam int TBL_N = 1 << SINE_TABLE_BITS;
    localparam int DEPTH = TBL_N + 2;

    typedef logic [TBL_DATA_W-1:0] rom_arr_t [DEPTH];

    // Quotient of two non-negative values by shift and subtract. It is only
    // evaluated while the table is built at elaboration.
    function automatic longint quot_u(input longint num, input longint den);
        longint q;
        longint r;
        int     b;
        q = 0;
        r = 0;
        for (b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((num >>> b) & longint'(1));
            if (r >= den) begin
                r = r - den;
                q = q | (longint'(1) <<< b);
            end
        end
        return q;
    endfunction

    // Points of sin over [0, pi/2] from an integer Taylor series, built at
    // elaboration. The extra last entry repeats the end point so that the
    // upper read of the last interval stays flat.
    function automatic rom_arr_t build_table();
        rom_arr_t tbl;
        longint   a;
        longint   a2;
        longint   term;
        longint   sum;
        int       i;
        int       k;
        for (i = 0; i <= TBL_N; i++) begin
            a    = (longint'(HALF_PI_Q30) * longint'(i)) >>> SINE_TABLE_BITS;
            a2   = (a * a) >>> 30;
            term = a;
            sum  = a;
            for (k = 1; k <= 10; k++) begin
                term = quot_u((term * a2) >>> 30, longint'((2 * k) * (2 * k + 1)));
                if ((k & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum > longint'(ONE_Q30)) begin
                sum = longint'(ONE_Q30);
            end
            if (sum < 0) begin
                sum = 0;
            end
            tbl[i] = sum[TBL_DATA_W-1:0];
        end
        tbl[TBL_N + 1] = tbl[TBL_N];
        return tbl;
    endfunction

    localparam rom_arr_t SINE_ROM = build_table();

    logic [TBL_DATA_W-1:0] rd_data_reg;

    // Registered read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= SINE_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/asat_datapath.sv =====
// ============================================================================
// asat_datapath
// Shared multiplier, working registers and channel state of the saturator.
// ============================================================================
module asat_datapath #(
    parameter int SAMPLE_BITS     = asat_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = asat_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asat_pkg::dp_ctrl_t            ctrl,
    input  logic [2*SAMPLE_BITS-1:0]      in_data,   // left, right
    input  logic                          cfg_we,
    input  logic [asat_pkg::DRIVE_W-1:0]  cfg_wdata,
    output logic [2*SAMPLE_BITS-1:0]      out_data   // left, right
);
    import asat_pkg::*;

    localparam int FRAC    = SAMPLE_BITS - 3;
    localparam int MUL_W   = ((SAMPLE_BITS > 31) ? SAMPLE_BITS : 31) + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int FR_W    = 30 - SINE_TABLE_BITS;
    localparam int ADDR_W  = SINE_TABLE_BITS + 1;
    localparam int MAG_W   = 33;
    localparam int SINE_W  = FRAC + 2;
    localparam int BLEND_W = FRAC + 1;

    localparam logic [BLEND_W-1:0]       ONE        = BLEND_W'(1) << FRAC;
    localparam logic signed [PROD_W-1:0] ONE_WIDE   = PROD_W'(1) << FRAC;
    localparam logic signed [PROD_W-1:0] ACC_HALF   = PROD_W'(1) << (FRAC - 1);
    localparam logic signed [PROD_W-1:0] BLEND_RND  = PROD_W'(1) << DRIVE_FRAC;
    localparam logic signed [MAG_W-1:0]  SINE_RND   = MAG_W'(1) << (29 - FRAC);
    localparam logic signed [PROD_W-1:0] SMAX       = (PROD_W'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [PROD_W-1:0] SMIN       = -(PROD_W'(1) << (SAMPLE_BITS - 1));
    localparam logic [DRIVE_W-1:0]       DRIVE_TOP  = DRIVE_W'(DRIVE_MAX);

    // Registers.
    logic signed [SAMPLE_BITS-1:0] x_reg    [2];
    logic signed [SINE_W-1:0]      prev_reg [2];
    logic [SAMPLE_BITS-1:0]        y_reg    [2];
    logic [SAMPLE_BITS-1:0]        out_reg  [2];
    logic [DRIVE_W-1:0]            drive_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic [30:0]                   pos_reg;
    logic                          neg_reg;
    logic [TBL_DATA_W-1:0]         lo_reg;
    logic signed [31:0]            diff_reg;
    logic signed [MAG_W-1:0]       mag_reg;
    logic signed [SINE_W-1:0]      sine_reg;
    logic [SINE_W-1:0]             sum_reg;
    logic [BLEND_W-1:0]            blend_reg;
    logic [BLEND_W-1:0]            omb_reg;
    logic signed [PROD_W-1:0]      acc_reg;

    // Next values and intermediate nets.
    logic signed [MUL_W-1:0]       mul_a;
    logic signed [MUL_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]      prod_next;
    logic [31:0]                   phase;
    logic [30:0]                   pos_next;
    logic [ADDR_W-1:0]             idx;
    logic [FR_W-1:0]               fr;
    logic [ADDR_W-1:0]             rom_addr;
    logic [TBL_DATA_W-1:0]         rom_q;
    logic signed [31:0]            diff_next;
    logic signed [PROD_W-1:0]      interp;
    logic signed [MAG_W-1:0]       mag_next;
    logic signed [MAG_W-1:0]       rnd_full;
    logic signed [MAG_W-1:0]       rnd_shift;
    logic signed [SINE_W-1:0]      rnd_mag;
    logic signed [SINE_W-1:0]      sine_next;
    logic signed [SINE_W:0]        pair_sum;
    logic signed [SINE_W:0]        pair_abs;
    logic [SINE_W-1:0]             sum_next;
    logic signed [PROD_W-1:0]      blend_raw;
    logic [BLEND_W-1:0]            blend_next;
    logic [BLEND_W-1:0]            omb_next;
    logic signed [PROD_W-1:0]      acc_load;
    logic signed [PROD_W-1:0]      acc_add;
    logic signed [PROD_W-1:0]      y_shift;
    logic [SAMPLE_BITS-1:0]        y_next;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (ctrl.mul_op)
            MUL_PHASE: begin
                mul_a = MUL_W'(x_reg[ctrl.chan]);
                mul_b = MUL_W'(INV_TWO_PI_Q32);
            end
            MUL_INTERP: begin
                mul_a = MUL_W'(diff_reg);
                mul_b = MUL_W'(fr);
            end
            MUL_BLEND: begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(drive_reg);
            end
            MUL_WET: begin
                mul_a = MUL_W'(sine_reg);
                mul_b = MUL_W'(blend_reg);
            end
            MUL_DRY: begin
                mul_a = MUL_W'(x_reg[ctrl.chan]);
                mul_b = MUL_W'(omb_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Phase in turns: the top two bits pick the quadrant; odd quadrants
    // run the quarter wave backward.
    assign phase    = prod_reg[FRAC+31 -: 32];
    assign pos_next = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]})
                                : {1'b0, phase[29:0]};
    assign idx      = pos_reg[30:FR_W];
    assign fr       = pos_reg[FR_W-1:0];
    assign rom_addr = (ctrl.rom_op == ROM_HI) ? idx + ADDR_W'(1) : idx;

    asat_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (ctrl.rom_op != ROM_IDLE),
        .rd_addr (rom_addr),
        .rd_data (rom_q)
    );

    // Linear interpolation between the two table points.
    assign diff_next = $signed({1'b0, rom_q}) - $signed({1'b0, lo_reg});
    assign interp    = prod_reg >>> FR_W;
    assign mag_next  = $signed({2'b00, lo_reg}) + $signed(interp[MAG_W-1:0]);

    // Round the Q1.30 magnitude to the sample fraction and apply the sign.
    assign rnd_full  = mag_reg + SINE_RND;
    assign rnd_shift = rnd_full >>> (30 - FRAC);
    assign rnd_mag   = $signed(rnd_shift[SINE_W-1:0]);
    assign sine_next = neg_reg ? -rnd_mag : rnd_mag;

    // Magnitude of the previous plus the current sine.
    assign pair_sum = (SINE_W+1)'(prev_reg[ctrl.chan]) + (SINE_W+1)'(sine_reg);
    assign pair_abs = pair_sum[SINE_W] ? -pair_sum : pair_sum;
    assign sum_next = pair_abs[SINE_W-1:0];

    // Blend factor, rounded and held to at most one.
    assign blend_raw  = (prod_reg + BLEND_RND) >>> (DRIVE_FRAC + 1);
    assign blend_next = (blend_raw > ONE_WIDE) ? ONE : blend_raw[BLEND_W-1:0];
    assign omb_next   = ONE - blend_reg;

    // Crossfade accumulation and final saturation.
    assign acc_load = prod_reg + ACC_HALF;
    assign acc_add  = acc_reg + prod_reg;
    assign y_shift  = acc_reg >>> FRAC;

    always_comb begin
        if (y_shift > SMAX) begin
            y_next = SMAX[SAMPLE_BITS-1:0];
        end else if (y_shift < SMIN) begin
            y_next = SMIN[SAMPLE_BITS-1:0];
        end else begin
            y_next = y_shift[SAMPLE_BITS-1:0];
        end
    end

    // Drive register and per-channel sine history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg   <= '0;
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
        end else begin
            if (cfg_we) begin
                drive_reg <= (cfg_wdata > DRIVE_TOP) ? DRIVE_TOP : cfg_wdata;
            end
            if (ctrl.dp_op == DP_SUM) begin
                prev_reg[ctrl.chan] <= sine_reg;
            end
        end
    end

    // Working registers, updated as the control word says.
    always_ff @(posedge aclk) begin
        if (ctrl.in_load) begin
            x_reg[0] <= $signed(in_data[SAMPLE_BITS-1:0]);
            x_reg[1] <= $signed(in_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
        if (ctrl.mul_op != MUL_HOLD) begin
            prod_reg <= prod_next;
        end
        case (ctrl.dp_op)
            DP_POS: begin
                pos_reg <= pos_next;
                neg_reg <= phase[31];
            end
            DP_LATCH_LO: lo_reg    <= rom_q;
            DP_DIFF:     diff_reg  <= diff_next;
            DP_MAG:      mag_reg   <= mag_next;
            DP_SINE:     sine_reg  <= sine_next;
            DP_SUM:      sum_reg   <= sum_next;
            DP_BLEND:    blend_reg <= blend_next;
            DP_OMB:      omb_reg   <= omb_next;
            DP_ACC_LOAD: acc_reg   <= acc_load;
            DP_ACC_ADD:  acc_reg   <= acc_add;
            DP_OUT:      y_reg[ctrl.chan] <= y_next;
            default: ;
        endcase
        if (ctrl.out_load) begin
            out_reg[0] <= y_reg[0];
            out_reg[1] <= y_reg[1];
        end
    end

    assign out_data = {out_reg[1], out_reg[0]};

endmodule

// ===== hw/rtl/asat_sequencer.sv =====
// ============================================================================
// asat_sequencer
// Step counter and microcode table that run the datapath, plus handshakes.
// ============================================================================
module asat_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output asat_pkg::dp_ctrl_t  ctrl
);
    import asat_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                chan_reg;
    logic                chan_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    ucode_t              uc;
    logic                in_load;
    logic                out_load;
    logic                out_free;

    assign uc       = ucode_word(step_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_load  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            chan_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            chan_reg     <= chan_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next step, channel turnaround and output hand-off.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        chan_next  = chan_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_load) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                    chan_next  = 1'b0;
                end
            end
            ST_RUN: begin
                case (uc.seq_op)
                    SEQ_NEXT: step_next = step_reg + STEP_W'(1);
                    SEQ_CHAN: begin
                        if (!chan_reg) begin
                            chan_next = 1'b1;
                            step_next = '0;
                        end else begin
                            step_next = step_reg + STEP_W'(1);
                        end
                    end
                    SEQ_END: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase

        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    // Datapath controls; no program operation is issued while idle.
    always_comb begin
        ctrl.chan     = chan_reg;
        ctrl.in_load  = in_load;
        ctrl.out_load = out_load;
        if (state_reg == ST_RUN) begin
            ctrl.mul_op = uc.mul_op;
            ctrl.rom_op = uc.rom_op;
            ctrl.dp_op  = uc.dp_op;
        end else begin
            ctrl.mul_op = MUL_HOLD;
            ctrl.rom_op = ROM_IDLE;
            ctrl.dp_op  = DP_NONE;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hw/rtl/adaptive_sine_saturator.sv =====
// ============================================================================
// adaptive_sine_saturator
// Stereo sine waveshaper with a drive-controlled adaptive crossfade.
// ============================================================================
// Each slave beat carries one stereo pair of signed Q2.(SAMPLE_BITS-3)
// samples; each master beat returns the shaped pair in the same format.
// Per channel the block looks up sin(x) in a quarter-wave table with linear
// interpolation and crossfades dry and sine by |previous sine + sine| times
// half the drive. The drive register is written through cfg_we/cfg_wdata as
// a Q1.16 fraction; values above 1.0 are held to 1.0. Write it while idle.
// One shared multiplier and one table port are run by a 16-step microcode
// program: 15 steps per channel plus one hand-off step. The result beat
// shows on the master side once the hand-off step has loaded the output
// register, and a new pair is taken only after the current one is handed off.
// A finished pair sits in the output register while the next pair is taken
// in; if the receiver stalls, the sequencer waits at its hand-off step
// until the output register is free. Reset clears the drive register and
// the stored sine of both channels.
// ============================================================================
module adaptive_sine_saturator #(
    parameter int SAMPLE_BITS     = asat_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = asat_pkg::SINE_TABLE_BITS_DEF,
    localparam int TDATA_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [TDATA_W-1:0]            s_tdata,    // left_in, right_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_W-1:0]            m_tdata,    // left_out, right_out
    input  logic                          cfg_we,
    input  logic [asat_pkg::DRIVE_W-1:0]  cfg_wdata   // drive_amount
);
    import asat_pkg::*;

    dp_ctrl_t                  ctrl;
    logic [2*SAMPLE_BITS-1:0]  out_data;

    // Program sequencer and handshakes.
    asat_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    // Arithmetic, table and state.
    asat_datapath #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .in_data   (s_tdata[2*SAMPLE_BITS-1:0]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_data  (out_data)
    );

    assign m_tdata = TDATA_W'(out_data);

endmodule

// ===== test/asat_checker.sv =====
// ============================================================================
// asat_checker
// Watches both stream channels and the drive register of the saturator.
// ============================================================================
// Every accepted slave beat is run through a bit-exact model of the sine
// waveshaper and the expected output pair is queued. Each master beat is
// checked field by field against the oldest queued pair. Drive writes and
// reset are tracked so that the model keeps the same state as the block.
// ============================================================================
module asat_checker #(
    parameter int SAMPLE_W = asat_pkg::SAMPLE_BITS_DEF,
    parameter int TBL_BITS = asat_pkg::SINE_TABLE_BITS_DEF,
    parameter int TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [TDATA_W-1:0]           s_tdata,    // left_in, right_in
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [TDATA_W-1:0]           m_tdata,    // left_out, right_out
    input  logic                         cfg_we,
    input  logic [asat_pkg::DRIVE_W-1:0] cfg_wdata,  // drive_amount
    output int                           mismatches,
    output int                           pending
);

    localparam int  FRAC     = SAMPLE_W - 3;
    localparam int  TBL_N    = 1 << TBL_BITS;
    localparam int  FR_SHIFT = 30 - TBL_BITS;
    localparam longint ONE   = longint'(1) <<< FRAC;
    localparam longint MAXV  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;

    // One stereo pair, left channel in the low bits.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } stereo_t;

    longint  quarter_wave [0:TBL_N+1];
    longint  drive_level;
    longint  last_sine [2];
    stereo_t shaped_q [$];

    // Quarter-wave sine points in Q1.30, from an integer Taylor series.
    initial begin
        longint ang, sq, term, acc;
        for (int i = 0; i <= TBL_N; i++) begin
            ang  = (longint'(asat_pkg::HALF_PI_Q30) * i) >>> TBL_BITS;
            sq   = (ang * ang) >>> 30;
            term = ang;
            acc  = ang;
            for (int k = 1; k <= 10; k++) begin
                term = ((term * sq) >>> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            if (acc > asat_pkg::ONE_Q30) begin
                acc = longint'(asat_pkg::ONE_Q30);
            end
            if (acc < 0) begin
                acc = 0;
            end
            quarter_wave[i] = acc;
        end
        quarter_wave[TBL_N+1] = quarter_wave[TBL_N];
    end

    // Table sine of a sample: phase in turns, quadrant fold, interpolation.
    function automatic longint table_sine(input longint x);
        logic [63:0] prod;
        logic [31:0] phase;
        logic [31:0] pos;
        longint      idx, fr, lo, hi, mag;
        prod  = x * longint'(asat_pkg::INV_TWO_PI_Q32);
        phase = prod[FRAC+31:FRAC];
        pos   = {2'b00, phase[29:0]};
        if (phase[30]) begin
            pos = 32'h4000_0000 - pos;
        end
        idx = longint'(pos >> FR_SHIFT);
        fr  = longint'(pos & ((32'd1 << FR_SHIFT) - 32'd1));
        if (idx > TBL_N) begin
            idx = TBL_N;
        end
        lo  = quarter_wave[idx];
        hi  = quarter_wave[idx+1];
        mag = lo + (((hi - lo) * fr) >>> FR_SHIFT);
        mag = (mag + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
        return phase[31] ? -mag : mag;
    endfunction

    // Crossfade of dry and sine for one channel; updates its stored sine.
    function automatic logic [SAMPLE_W-1:0] shape_sample(
        input logic signed [SAMPLE_W-1:0] dry,
        input int                         ch
    );
        longint x, s, total, blend, acc, y;
        x     = longint'(dry);
        s     = table_sine(x);
        total = last_sine[ch] + s;
        if (total < 0) begin
            total = -total;
        end
        blend = (total * drive_level + 65536) >>> 17;
        if (blend > ONE) begin
            blend = ONE;
        end
        acc = x * (ONE - blend) + s * blend + (ONE >>> 1);
        y   = acc >>> FRAC;
        if (y > MAXV) begin
            y = MAXV;
        end
        if (y < -MAXV - 1) begin
            y = -MAXV - 1;
        end
        last_sine[ch] = s;
        return y[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Track writes and beats at every rising edge.
    always @(posedge aclk) begin
        stereo_t dry_pair, got, want;
        if (!aresetn) begin
            drive_level  = 0;
            last_sine[0] = 0;
            last_sine[1] = 0;
            shaped_q.delete();
        end else begin
            if (cfg_we) begin
                drive_level = longint'((cfg_wdata > asat_pkg::DRIVE_MAX) ?
                                       asat_pkg::DRIVE_MAX : cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                dry_pair   = s_tdata[2*SAMPLE_W-1:0];
                want.left  = shape_sample(dry_pair.left, 0);
                want.right = shape_sample(dry_pair.right, 1);
                shaped_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[2*SAMPLE_W-1:0];
                if (shaped_q.size() == 0) begin
                    report_mismatch($sformatf("output beat with no pair pending: %h",
                                              m_tdata));
                end else begin
                    want = shaped_q.pop_front();
                    if (got.left !== want.left) begin
                        report_mismatch($sformatf("left_out got %0d expected %0d",
                                                  got.left, want.left));
                    end
                    if (got.right !== want.right) begin
                        report_mismatch($sformatf("right_out got %0d expected %0d",
                                                  got.right, want.right));
                    end
                end
            end
        end
        pending = shaped_q.size();
    end

endmodule

// ===== test/adaptive_sine_saturator_test.sv =====
// ============================================================================
// adaptive_sine_saturator_test
// Stimulus and verdict for the adaptive sine saturator.
// ============================================================================
// A short directed run covers the sample extremes and the quadrant points
// at zero and full drive, then random pairs follow under several drive
// settings, including out-of-range ones that the block must hold to 1.0.
// Both the sender and the receiver pause at random; some phases run with
// no pauses at all. The checker instance predicts and compares every beat.
// ============================================================================
module adaptive_sine_saturator_test;

    localparam int SAMPLE_W       = asat_pkg::SAMPLE_BITS_DEF;
    localparam int TDATA_W        = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 107;

    localparam logic [SAMPLE_W-1:0] MAX_POS = 24'sd8388607;
    localparam logic [SAMPLE_W-1:0] MAX_NEG = -24'sd8388608;
    localparam logic [SAMPLE_W-1:0] HALF_PI = 24'sd3294199;    // pi/2 in Q2.21
    localparam logic [SAMPLE_W-1:0] FULL_PI = 24'sd6588397;    // pi in Q2.21
    localparam logic [SAMPLE_W-1:0] TWO     = 24'sd4194304;    // 2.0 in Q2.21

    logic                         aclk;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [TDATA_W-1:0]           s_tdata   = '0;    // left_in, right_in
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [TDATA_W-1:0]           m_tdata;           // left_out, right_out
    logic                         cfg_we    = 1'b0;
    logic [asat_pkg::DRIVE_W-1:0] cfg_wdata = '0;    // drive_amount

    int errors;
    int pending;
    int quiet_cycles = 0;
    bit steady       = 1'b0;

    adaptive_sine_saturator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    asat_checker shaper_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (errors),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Pause length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(21, 80);
    endfunction

    // Receiver: ready most of the time, with random stalls.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall = pick_gap();
                end
            end
        end
    end

    // Watchdog: too long without any beat ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one pair and return at the falling edge after its beat.
    // Valid stays high when no pause follows, so it is never dropped and
    // raised in the same step.
    task automatic send_pair(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every pending pair has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_drive(input logic [asat_pkg::DRIVE_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [SAMPLE_W-1:0]          l_val, r_val;
        logic [asat_pkg::DRIVE_W-1:0] drive_plan [8];
        l_val = '0;
        r_val = '0;
        drive_plan = '{17'd65535, 17'd131071, 17'd1, 17'd32768,
                       17'd65537, 17'd0, 17'd0, 17'd65536};
        drive_plan[6] = asat_pkg::DRIVE_W'($urandom_range(0, 131071));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset drive of zero: output should equal the dry input.
        send_pair('0, '0);
        send_pair(MAX_POS, MAX_NEG);
        send_pair(MAX_NEG, MAX_POS);
        send_pair(24'sd1, -24'sd1);
        send_pair(HALF_PI, -HALF_PI);
        send_pair(FULL_PI, -FULL_PI);

        // Full drive: repeated peaks push the blend to its limit.
        drain();
        write_drive(asat_pkg::DRIVE_W'(asat_pkg::DRIVE_MAX));
        send_pair(HALF_PI, -HALF_PI);
        send_pair(HALF_PI, -HALF_PI);
        send_pair(HALF_PI, -HALF_PI);
        send_pair(MAX_POS, MAX_NEG);
        send_pair(MAX_NEG, MAX_POS);
        send_pair('0, '0);
        send_pair(FULL_PI, -FULL_PI);
        send_pair(-24'sd1, 24'sd1);
        send_pair(TWO, -TWO);
        send_pair(MAX_POS, MAX_POS);
        send_pair(MAX_NEG, MAX_NEG);
        send_pair(-HALF_PI, HALF_PI);

        // Random phases, one drive setting each.
        for (int p = 0; p < 8; p++) begin
            drain();
            write_drive(drive_plan[p]);
            steady = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 3))
                    0, 1: begin
                        l_val = SAMPLE_W'($urandom);
                        r_val = SAMPLE_W'($urandom);
                    end
                    2: begin
                        l_val = SAMPLE_W'($urandom_range(0, 4095) - 2048);
                        r_val = SAMPLE_W'($urandom_range(0, 4095) - 2048);
                    end
                    default: begin
                        // Near-repeat of the last pair, so the stored sine
                        // and the new one add up.
                        l_val = SAMPLE_W'(l_val + $urandom_range(0, 63) - 32);
                        r_val = SAMPLE_W'(r_val + $urandom_range(0, 63) - 32);
                    end
                endcase
                send_pair(l_val, r_val);
            end
        end
        steady = 1'b0;

        drain();
        repeat (40) @(negedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
